// ===== rtl/depq_pkg.sv =====
// Package for the double-ended priority queue unit.
// Holds the command and error codes, port widths, defaults and the cell control struct.
// Depends on nothing; used by every file in rtl.
package depq_pkg;

    localparam int DATA_W            = 32;
    localparam int COUNT_W           = 11;
    localparam int DEFAULT_CAPACITY  = 1024;
    localparam int DEFAULT_VALUE_W   = 32;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP_MIN = 2'd1,
        CMD_POP_MAX = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_POP_EMPTY  = 2'd1,
        ERR_PUSH_FULL  = 2'd2,
        ERR_RESERVED   = 2'd3
    } err_t;

    // Operation broadcast to every cell of a chain at once.
    typedef struct packed {
        logic insert;     // place the broadcast key in sorted position
        logic shift;      // every cell takes its right neighbor (head leaves)
        logic drop_last;  // the last occupied cell becomes empty
    } cell_ctrl_t;

endpackage

// ===== rtl/depq_cell.sv =====
// One cell of a sorted chain: a valid bit and a key.
// Depends on depq_pkg for the control struct.
module depq_cell #(
    parameter int  VALUE_WIDTH = depq_pkg::DEFAULT_VALUE_W,
    parameter bit  DESCEND     = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  depq_pkg::cell_ctrl_t          ctrl,
    input  logic signed [VALUE_WIDTH-1:0] key,
    input  logic                          left_valid,
    input  logic                          left_after,
    input  logic signed [VALUE_WIDTH-1:0] left_key,
    input  logic                          right_valid,
    input  logic signed [VALUE_WIDTH-1:0] right_key,
    output logic                          valid,
    output logic signed [VALUE_WIDTH-1:0] stored_key,
    output logic                          after
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic signed [VALUE_WIDTH-1:0] key_next;

    // An empty cell counts as lying after any key.
    always_comb
    begin
        if (DESCEND)
        begin
            after = !valid_reg || (key_reg < key);
        end
        else
        begin
            after = !valid_reg || (key_reg > key);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        priority if (ctrl.insert)
        begin
            if (after)
            begin
                key_next   = left_after ? left_key : key;
                valid_next = valid_reg | left_valid;
            end
        end
        else if (ctrl.shift)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
        else if (ctrl.drop_last)
        begin
            valid_next = valid_reg & right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign valid      = valid_reg;
    assign stored_key = key_reg;

endmodule

// ===== rtl/depq_chain.sv =====
// A row of depq_cell instances kept sorted, ascending or descending.
// Depends on depq_pkg and depq_cell.
module depq_chain #(
    parameter int CAPACITY    = depq_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = depq_pkg::DEFAULT_VALUE_W,
    parameter bit DESCEND     = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  depq_pkg::cell_ctrl_t          ctrl,
    input  logic signed [VALUE_WIDTH-1:0] key,
    output logic                          head_valid,
    output logic signed [VALUE_WIDTH-1:0] head_key
);

    logic                          valid_w [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] key_w   [CAPACITY];
    logic                          after_w [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                          lv;
        logic                          la;
        logic signed [VALUE_WIDTH-1:0] lk;
        logic                          rv;
        logic signed [VALUE_WIDTH-1:0] rk;

        // The head sees an occupied neighbor that lies before any key.
        if (i == 0)
        begin : g_head
            assign lv = 1'b1;
            assign la = 1'b0;
            assign lk = '0;
        end
        else
        begin : g_body
            assign lv = valid_w[i-1];
            assign la = after_w[i-1];
            assign lk = key_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign rv = 1'b0;
            assign rk = '0;
        end
        else
        begin : g_inner
            assign rv = valid_w[i+1];
            assign rk = key_w[i+1];
        end

        depq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .DESCEND     (DESCEND)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .key         (key),
            .left_valid  (lv),
            .left_after  (la),
            .left_key    (lk),
            .right_valid (rv),
            .right_key   (rk),
            .valid       (valid_w[i]),
            .stored_key  (key_w[i]),
            .after       (after_w[i])
        );
    end

    assign head_valid = valid_w[0];
    assign head_key   = key_w[0];

endmodule

// ===== rtl/double_ended_priority_queue_unit.sv =====
// Top level of the double-ended priority queue unit.
// Depends on depq_pkg and depq_chain (which builds on depq_cell).
//
// The unit keeps a multiset of up to CAPACITY signed values of VALUE_WIDTH bits.
// An item is a command (push, pop minimum, pop maximum or query) and is taken
// at a rising edge where start is high and busy is low. For every item, in the
// cycle after acceptance the cell rows settle (busy is high), and in the
// following cycle the result is on the output ports for exactly one cycle with
// done high. The receiver cannot stall, so it must take the result in that
// cycle. A new item may be started in the same cycle that the previous result
// is shown, but not while busy is high. The values are held twice, in an
// ascending row of cells whose head is the minimum and a descending row whose
// head is the maximum. Every cell compares its key with the broadcast key and
// takes its own, its left neighbor's or the new key, so a push updates every
// cell at once at any fill level. A pop shifts one row toward its head and
// empties the last occupied cell of the other row. A pop on an empty queue
// reports error 1 and changes nothing; a push into a full queue reports error
// 2 and drops the value. Pushed values are sign-extended or cut to VALUE_WIDTH
// bits, and reported values are sign-extended or cut to 32 bits. Minimum and
// maximum read as zero when the queue is empty. There is no clearing pass
// after reset: empty cells are marked by valid bits.
module double_ended_priority_queue_unit #(
    parameter int CAPACITY    = depq_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = depq_pkg::DEFAULT_VALUE_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic signed [depq_pkg::DATA_W-1:0]  value,
    output logic                                done,
    output logic signed [depq_pkg::DATA_W-1:0]  removed_value,
    output logic signed [depq_pkg::DATA_W-1:0]  min_value,
    output logic signed [depq_pkg::DATA_W-1:0]  max_value,
    output logic [depq_pkg::COUNT_W-1:0]        entry_count,
    output logic                                is_empty,
    output logic [1:0]                          error
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W = depq_pkg::DATA_W;
    localparam int OUT_CW = depq_pkg::COUNT_W;

    // Control state.
    logic              pending_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Result held between acceptance and presentation.
    logic signed [DATA_W-1:0] removed_hold_reg;
    logic [1:0]               err_hold_reg;

    // Output registers.
    logic signed [DATA_W-1:0] removed_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic [OUT_CW-1:0]        count_out_reg;
    logic                     empty_reg;
    logic [1:0]               error_reg;

    logic                          accept;
    logic                          is_full;
    logic                          is_zero;
    logic                          do_push;
    logic                          do_pop_min;
    logic                          do_pop_max;
    logic signed [VALUE_WIDTH-1:0] key_in;
    depq_pkg::cell_ctrl_t          asc_ctrl;
    depq_pkg::cell_ctrl_t          desc_ctrl;
    logic                          asc_valid;
    logic                          desc_valid;
    logic signed [VALUE_WIDTH-1:0] asc_key;
    logic signed [VALUE_WIDTH-1:0] desc_key;
    logic signed [DATA_W-1:0]      min_ext;
    logic signed [DATA_W-1:0]      max_ext;
    logic [OUT_CW-1:0]             count_ext;
    logic [1:0]                    err_now;
    logic signed [DATA_W-1:0]      removed_now;

    assign accept  = start && !pending_reg;
    assign is_full = (count_reg == CNT_W'(CAPACITY));
    assign is_zero = (count_reg == '0);

    assign do_push    = accept && (cmd == depq_pkg::CMD_PUSH) && !is_full;
    assign do_pop_min = accept && (cmd == depq_pkg::CMD_POP_MIN) && !is_zero;
    assign do_pop_max = accept && (cmd == depq_pkg::CMD_POP_MAX) && !is_zero;

    // Value and count width conversions.
    if (VALUE_WIDTH >= DATA_W)
    begin : g_wide
        assign key_in  = VALUE_WIDTH'(value);
        assign min_ext = asc_key[DATA_W-1:0];
        assign max_ext = desc_key[DATA_W-1:0];
    end
    else
    begin : g_narrow
        assign key_in  = value[VALUE_WIDTH-1:0];
        assign min_ext = {{(DATA_W - VALUE_WIDTH){asc_key[VALUE_WIDTH-1]}}, asc_key};
        assign max_ext = {{(DATA_W - VALUE_WIDTH){desc_key[VALUE_WIDTH-1]}}, desc_key};
    end

    if (CNT_W >= OUT_CW)
    begin : g_cnt_cut
        assign count_ext = count_reg[OUT_CW-1:0];
    end
    else
    begin : g_cnt_ext
        assign count_ext = {{(OUT_CW - CNT_W){1'b0}}, count_reg};
    end

    // The ascending row loses its head on pop minimum and its tail on pop
    // maximum; the descending row the other way round.
    always_comb
    begin
        asc_ctrl.insert     = do_push;
        asc_ctrl.shift      = do_pop_min;
        asc_ctrl.drop_last  = do_pop_max;
        desc_ctrl.insert    = do_push;
        desc_ctrl.shift     = do_pop_max;
        desc_ctrl.drop_last = do_pop_min;
    end

    depq_chain #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .DESCEND     (1'b0)
    ) u_asc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (asc_ctrl),
        .key        (key_in),
        .head_valid (asc_valid),
        .head_key   (asc_key)
    );

    depq_chain #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .DESCEND     (1'b1)
    ) u_desc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (desc_ctrl),
        .key        (key_in),
        .head_valid (desc_valid),
        .head_key   (desc_key)
    );

    // Error code and removed value are known at acceptance.
    always_comb
    begin
        err_now     = depq_pkg::ERR_NONE;
        removed_now = '0;
        unique case (cmd)
            depq_pkg::CMD_PUSH:
            begin
                if (is_full)
                begin
                    err_now = depq_pkg::ERR_PUSH_FULL;
                end
            end
            depq_pkg::CMD_POP_MIN:
            begin
                if (is_zero)
                begin
                    err_now = depq_pkg::ERR_POP_EMPTY;
                end
                else
                begin
                    removed_now = min_ext;
                end
            end
            depq_pkg::CMD_POP_MAX:
            begin
                if (is_zero)
                begin
                    err_now = depq_pkg::ERR_POP_EMPTY;
                end
                else
                begin
                    removed_now = max_ext;
                end
            end
            default:
            begin
                err_now = depq_pkg::ERR_NONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop_min || do_pop_max)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            pending_reg <= accept;
            done_reg    <= pending_reg;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_hold_reg <= removed_now;
            err_hold_reg     <= err_now;
        end
        if (pending_reg)
        begin
            removed_reg   <= removed_hold_reg;
            error_reg     <= err_hold_reg;
            min_reg       <= asc_valid ? min_ext : '0;
            max_reg       <= desc_valid ? max_ext : '0;
            count_out_reg <= count_ext;
            empty_reg     <= is_zero;
        end
    end

    assign busy          = pending_reg;
    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign min_value     = min_reg;
    assign max_value     = max_reg;
    assign entry_count   = count_out_reg;
    assign is_empty      = empty_reg;
    assign error         = error_reg;

`ifndef SYNTHESIS
    // A result only follows settling with busy high.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // Both row heads are valid exactly when the counter is nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (asc_valid == !is_zero) && (desc_valid == !is_zero))
        else $error("row heads disagree with the entry counter");

    // The counter never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(CAPACITY))
        else $error("entry counter above capacity");

    // A full push leaves the count unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_full && (cmd == depq_pkg::CMD_PUSH)) |=> $stable(count_reg))
        else $error("push into a full queue changed the count");
`endif

endmodule
